[hdl/slrt_pkg.sv]
// Shared types and constants for the span list range trim core.
package slrt_pkg;
    localparam int LINES        = 64;
    localparam int SPANS        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int LINE_W       = 6;
    localparam int COL_W        = 10;
    localparam int LEN_W        = 11;
    localparam int POS_W        = $clog2(SPANS);
    localparam int CNT_W        = $clog2(SPANS + 1);
    localparam int ADDR_W       = $clog2(LINES * SPANS);
    localparam int ENTRY_W      = COL_W + LEN_W + 1 + PAYLOAD_BITS;
    localparam int SIGNED_W     = LEN_W + 2;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_TRIM   = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0]        start;
        logic [LEN_W-1:0]        len;
        logic                    wrapped;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_LWAIT = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_STORE = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    // per-cell commands, one broadcast per cycle
    typedef enum logic [3:0] {
        CMD_HOLD   = 4'b0001,
        CMD_SHIFTL = 4'b0010,
        CMD_SHIFTR = 4'b0100,
        CMD_WRITE  = 4'b1000
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [POS_W-1:0]  pos;
        t_entry            data;
    } t_cell_ctl;
endpackage

[hdl/slrt_ram.sv]
// Generic single-port RAM with registered read.
module slrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/slrt_cell.sv]
// One cell of the working row: holds one span and trades with its neighbors.
module slrt_cell (
    input  logic                        i_clk,
    input  logic [slrt_pkg::POS_W-1:0]  i_index,
    input  slrt_pkg::t_cell_ctl         i_ctl,
    input  logic                        i_load,
    input  slrt_pkg::t_entry            i_load_data,
    input  slrt_pkg::t_entry            i_left,
    input  slrt_pkg::t_entry            i_right,
    output slrt_pkg::t_entry            o_entry
);
    slrt_pkg::t_entry r_entry;
    slrt_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_load) begin
            n_entry = i_load_data;
        end else begin
            unique case (i_ctl.cmd)
                slrt_pkg::CMD_SHIFTL: if (i_index >= i_ctl.pos) n_entry = i_right;
                slrt_pkg::CMD_SHIFTR: begin
                    if (i_index > i_ctl.pos) n_entry = i_left;
                    else if (i_index == i_ctl.pos) n_entry = i_ctl.data;
                end
                slrt_pkg::CMD_WRITE:  if (i_index == i_ctl.pos) n_entry = i_ctl.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule

[hdl/span_list_range_trim_core.sv]
// Span list range trim core: per-line span tables with append and range trim.
// Throughput: one item at a time; the line is loaded into a row of cells,
// walked one span per cycle (a split writes the head, then the tail), then
// written back from the row. Span memory has one port, so load and store
// each move one entry at a time. Reset clears control, then a pass over
// all LINES lines zeroes the per-line counts.
module span_list_range_trim_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [5:0]  i_line,
    input  logic [9:0]  i_start_column,
    input  logic [10:0] i_length,
    input  logic        i_wrapped_in,
    input  logic [31:0] i_payload_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic        o_wrapped_removed,
    output logic        o_has_following,
    output logic [3:0]  o_following_position
);
    localparam int PW = slrt_pkg::POS_W;
    localparam int CW = slrt_pkg::CNT_W;
    localparam int SW = slrt_pkg::SIGNED_W;

    slrt_pkg::t_state r_state, n_state;
    logic [slrt_pkg::LINE_W-1:0] r_line;
    logic [slrt_pkg::COL_W-1:0] r_x;
    logic [slrt_pkg::LEN_W-1:0] r_len;
    logic r_op, r_win;
    logic [slrt_pkg::PAYLOAD_BITS-1:0] r_pay;
    logic [CW-1:0] r_cnt, r_i, r_k;
    logic r_split;
    logic r_status, r_wrem, r_hasf;
    logic [3:0] r_fpos;
    logic r_ovalid;
    logic r_clr;
    logic [slrt_pkg::LINE_W-1:0] r_clr_idx;

    slrt_pkg::t_entry w_row [slrt_pkg::SPANS];
    slrt_pkg::t_cell_ctl w_ctl;
    logic w_load;
    logic [PW-1:0] w_load_idx;
    slrt_pkg::t_entry w_rdata;

    logic w_we;
    logic [slrt_pkg::ADDR_W-1:0] w_addr;
    slrt_pkg::t_entry w_wdata;

    logic w_cwe;
    logic [slrt_pkg::LINE_W-1:0] w_caddr;
    logic [CW-1:0] w_cwdata;
    logic [CW-1:0] w_crdata;

    assign o_ready = r_state == slrt_pkg::ST_IDLE && !r_ovalid && !r_clr;
    wire w_acc = i_valid && o_ready;

    wire [PW-1:0] w_ipos = r_i[PW-1:0];
    slrt_pkg::t_entry w_cur;
    assign w_cur = w_row[w_ipos];
    wire signed [SW-1:0] w_sx  = SW'($signed({1'b0, r_x}));
    wire signed [SW-1:0] w_ex  = w_sx + SW'($signed({1'b0, r_len})) - SW'(1);
    wire signed [SW-1:0] w_csx = SW'($signed({1'b0, w_cur.start}));
    wire signed [SW-1:0] w_cex = w_csx + SW'($signed({1'b0, w_cur.len})) - SW'(1);
    wire [slrt_pkg::COL_W-1:0] w_ex1 = slrt_pkg::COL_W'(w_ex + SW'(1));
    wire [slrt_pkg::LEN_W-1:0] w_tail = slrt_pkg::LEN_W'(w_cex - w_ex);
    wire [slrt_pkg::LEN_W-1:0] w_head = slrt_pkg::LEN_W'(w_sx - w_csx);

    slrt_ram #(.WIDTH(slrt_pkg::ENTRY_W), .DEPTH(slrt_pkg::LINES * slrt_pkg::SPANS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    slrt_ram #(.WIDTH(CW), .DEPTH(slrt_pkg::LINES)) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (w_cwe),
        .i_addr (w_caddr),
        .i_wdata(w_cwdata),
        .o_rdata(w_crdata)
    );

    for (genvar g = 0; g < slrt_pkg::SPANS; g++) begin : g_cell
        slrt_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (PW'(g)),
            .i_ctl      (w_ctl),
            .i_load     (w_load && w_load_idx == PW'(g)),
            .i_load_data(w_rdata),
            .i_left     (w_row[(g + slrt_pkg::SPANS - 1) % slrt_pkg::SPANS]),
            .i_right    (w_row[(g + 1) % slrt_pkg::SPANS]),
            .o_entry    (w_row[g])
        );
    end

    // count store: cleared after reset, read at accept, written back when done
    always_comb begin
        w_cwe = 1'b0;
        w_cwdata = r_cnt;
        w_caddr = (r_state == slrt_pkg::ST_IDLE) ? i_line : r_line;
        if (r_clr) begin
            w_cwe = 1'b1;
            w_cwdata = '0;
            w_caddr = r_clr_idx;
        end else if (r_state == slrt_pkg::ST_DONE) begin
            if (r_op == slrt_pkg::OP_APPEND) begin
                w_cwe = r_cnt < CW'(slrt_pkg::SPANS);
                w_cwdata = r_cnt + CW'(1);
            end else begin
                w_cwe = 1'b1;
            end
        end
    end

    always_comb begin
        w_we = 1'b0;
        w_addr = {r_line, r_k[PW-1:0]};
        w_wdata = w_row[r_k[PW-1:0]];
        w_load = r_state == slrt_pkg::ST_LWAIT;
        w_load_idx = r_k[PW-1:0] - PW'(1);
        if (r_state == slrt_pkg::ST_DONE && r_op == slrt_pkg::OP_APPEND) begin
            w_we = r_cnt < CW'(slrt_pkg::SPANS);
            w_addr = {r_line, r_cnt[PW-1:0]};
            w_wdata = '{start: r_x, len: r_len, wrapped: r_win, payload: r_pay};
        end else if (r_state == slrt_pkg::ST_STORE) begin
            w_we = 1'b1;
        end
    end

    always_comb begin
        w_ctl = '{cmd: slrt_pkg::CMD_HOLD, pos: w_ipos, data: w_cur};
        if (r_state == slrt_pkg::ST_WALK && r_i < r_cnt) begin
            if (r_split) begin
                w_ctl.cmd = slrt_pkg::CMD_WRITE;
                w_ctl.data = '{start: w_ex1, len: w_tail, wrapped: 1'b0,
                               payload: w_cur.payload};
            end else if (w_cex < w_sx || w_csx > w_ex) begin
                w_ctl.cmd = slrt_pkg::CMD_HOLD;
            end else if (w_csx >= w_sx && w_cex <= w_ex) begin
                w_ctl.cmd = slrt_pkg::CMD_SHIFTL;
            end else if (w_csx < w_sx && w_cex <= w_ex) begin
                w_ctl.cmd = slrt_pkg::CMD_WRITE;
                w_ctl.data.len = w_head;
            end else if (w_csx >= w_sx) begin
                w_ctl.cmd = slrt_pkg::CMD_WRITE;
                w_ctl.data.start = w_ex1;
                w_ctl.data.len = w_tail;
            end else if (r_cnt < CW'(slrt_pkg::SPANS)) begin
                // copy to the right and shorten the head in place
                w_ctl.cmd = slrt_pkg::CMD_SHIFTR;
                w_ctl.pos = w_ipos;
                w_ctl.data.len = w_head;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slrt_pkg::ST_IDLE:  if (w_acc) n_state = slrt_pkg::ST_LOAD;
            slrt_pkg::ST_LOAD:
                n_state = (r_op == slrt_pkg::OP_APPEND) ? slrt_pkg::ST_DONE
                        : slrt_pkg::ST_LWAIT;
            slrt_pkg::ST_LWAIT: if (r_k == CW'(slrt_pkg::SPANS)) n_state = slrt_pkg::ST_WALK;
            slrt_pkg::ST_WALK:  if (r_split == 1'b0 && r_i >= r_cnt) n_state = slrt_pkg::ST_STORE;
            slrt_pkg::ST_STORE:
                if (r_k == CW'(slrt_pkg::SPANS - 1)) n_state = slrt_pkg::ST_DONE;
            slrt_pkg::ST_DONE:  n_state = slrt_pkg::ST_OUT;
            slrt_pkg::ST_OUT:   n_state = slrt_pkg::ST_IDLE;
            default:            n_state = slrt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slrt_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_clr <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == slrt_pkg::ST_OUT) r_ovalid <= 1'b1;
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + slrt_pkg::LINE_W'(1);
                if (r_clr_idx == slrt_pkg::LINE_W'(slrt_pkg::LINES - 1)) r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op <= i_operation;
            r_line <= i_line;
            r_x <= i_start_column;
            r_len <= i_length;
            r_win <= i_wrapped_in;
            r_pay <= i_payload_in;
            r_k <= '0;
            r_i <= '0;
            r_split <= 1'b0;
            r_status <= 1'b0;
            r_wrem <= 1'b0;
            r_hasf <= 1'b0;
            r_fpos <= '0;
        end
        unique case (r_state)
            slrt_pkg::ST_LOAD: begin
                r_cnt <= w_crdata;
                r_k <= CW'(1);
            end
            slrt_pkg::ST_LWAIT: begin
                r_k <= (r_k == CW'(slrt_pkg::SPANS)) ? '0 : r_k + CW'(1);
            end
            slrt_pkg::ST_WALK: begin
                if (r_split) begin
                    r_split <= 1'b0;
                    r_i <= r_cnt;
                end else if (r_i < r_cnt) begin
                    if (w_cex < w_sx) begin
                        r_i <= r_i + CW'(1);
                    end else if (w_csx > w_ex) begin
                        r_hasf <= 1'b1;
                        r_fpos <= 4'(r_i);
                        r_i <= r_cnt;
                    end else if (w_csx >= w_sx && w_cex <= w_ex) begin
                        if (w_cur.start == '0 && w_cur.wrapped) r_wrem <= 1'b1;
                        r_cnt <= r_cnt - CW'(1);
                    end else if (w_csx < w_sx && w_cex <= w_ex) begin
                        r_i <= r_i + CW'(1);
                    end else if (w_csx >= w_sx) begin
                        r_hasf <= 1'b1;
                        r_fpos <= 4'(r_i);
                        r_i <= r_cnt;
                    end else if (r_cnt >= CW'(slrt_pkg::SPANS)) begin
                        r_status <= 1'b1;
                        r_i <= r_cnt;
                    end else begin
                        // head shortened, copy shifted right; next write the tail
                        r_split <= 1'b1;
                        r_i <= r_i + CW'(1);
                        r_cnt <= r_cnt + CW'(1);
                        r_hasf <= 1'b1;
                        r_fpos <= 4'(r_i + CW'(1));
                    end
                end
            end
            slrt_pkg::ST_STORE: r_k <= r_k + CW'(1);
            slrt_pkg::ST_DONE: begin
                if (r_op == slrt_pkg::OP_APPEND && r_cnt >= CW'(slrt_pkg::SPANS))
                    r_status <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_status = r_status;
    assign o_wrapped_removed = r_wrem;
    assign o_has_following = r_hasf;
    assign o_following_position = r_fpos;
endmodule
